[sv/vsfu_pkg.sv]
package vsfu_pkg;

    // framebuffer size in words; runs reaching it are dropped
    localparam logic [31:0] FB_WORDS = 32'd16384;

    localparam int unsigned IDX_W      = 14;
    localparam int unsigned DIM_W      = 11;
    localparam int unsigned ADDR_W     = 30;
    localparam int unsigned DIV_STEPS  = IDX_W;
    localparam logic [3:0]  DIV_LAST   = 4'(DIV_STEPS - 1);

    // configuration register indexes
    localparam logic [2:0] CFG_REMAP_MODE      = 3'd0;
    localparam logic [2:0] CFG_FRAME_BASE_WORD = 3'd1;
    localparam logic [2:0] CFG_DST_ROW_WORDS   = 3'd2;
    localparam logic [2:0] CFG_SRC_WIDTH_WORDS = 3'd3;
    localparam logic [2:0] CFG_SRC_HEIGHT_ROWS = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_END   = 2'd1;
    localparam logic [1:0] KIND_DROP  = 2'd2;

    typedef enum logic [1:0] {
        TOK_END,
        TOK_HDR,
        TOK_DATA
    } tok_kind_t;

    typedef struct packed {
        tok_kind_t   kind;
        logic [31:0] word;
    } tok_t;

    typedef struct packed {
        logic              remap_mode;
        logic [ADDR_W-1:0] frame_base_word;
        logic [DIM_W-1:0]  dst_row_words;
        logic [DIM_W-1:0]  src_width_words;
        logic [DIM_W-1:0]  src_height_rows;
    } cfg_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_MUL,
        BK_CHK
    } bk_state_t;

endpackage

[sv/vsfu_fifo.sv]
module vsfu_fifo #(
    parameter int unsigned WIDTH = 34,
    parameter int unsigned DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             pop,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;

    assign full    = (cnt_reg == CNT_FULL);
    assign empty   = (cnt_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

[sv/vsfu_front.sv]
module vsfu_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [31:0]   s_tdata,
    input  logic          q_full,
    output logic          q_push,
    output vsfu_pkg::tok_t q_tok
);

    import vsfu_pkg::*;

    logic        in_run_reg, in_run_next;
    logic [16:0] left_reg, left_next;

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    always_comb begin
        in_run_next  = in_run_reg;
        left_next    = left_reg;
        q_tok.word   = s_tdata;
        q_tok.kind   = TOK_DATA;
        if (!in_run_reg) begin
            q_tok.kind = (s_tdata == '0) ? TOK_END : TOK_HDR;
        end
        if (q_push) begin
            if (!in_run_reg) begin
                if (s_tdata != '0) begin
                    in_run_next = 1'b1;
                    left_next   = {1'b0, s_tdata[31:16]} + 17'd1;
                end
            end else begin
                left_next = left_reg - 17'd1;
                if (left_reg == 17'd1) begin
                    in_run_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_run_reg <= 1'b0;
            left_reg   <= '0;
        end else begin
            in_run_reg <= in_run_next;
            left_reg   <= left_next;
        end
    end

endmodule

[sv/vsfu_back.sv]
module vsfu_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  vsfu_pkg::cfg_t      cfg,
    input  vsfu_pkg::tok_t      tok,
    input  logic                tok_avail,
    output logic                tok_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [1:0]          m_kind,
    output logic [29:0]         m_addr,
    output logic [31:0]         m_data
);

    import vsfu_pkg::*;

    bk_state_t   state_reg, state_next;

    logic [21:0] total_reg;
    logic [15:0] cnt1_reg, cnt1_next;
    logic [13:0] quo_reg, quo_next;
    logic [10:0] rem_reg, rem_next;
    logic [3:0]  div_cnt_reg, div_cnt_next;
    logic [25:0] rel_reg, rel_next;
    logic [26:0] prod_reg, prod_next;
    logic [29:0] cur_reg, cur_next;
    logic        bad_reg, bad_next;

    logic        m_valid_reg, m_valid_next;
    logic [1:0]  m_kind_reg, m_kind_next;
    logic [29:0] m_addr_reg, m_addr_next;
    logic [31:0] m_data_reg, m_data_next;

    logic        out_free;
    logic        is_hdr;
    logic [15:0] hdr_off;
    logic [13:0] hdr_idx;
    logic        hdr_bad;
    logic [11:0] trial;
    logic [11:0] diff;
    logic        trial_ge;
    logic [24:0] row_prod;
    logic [27:0] last_rel;

    assign out_free = !m_valid_reg || m_ready;
    assign is_hdr   = (tok.kind == TOK_HDR);
    assign tok_pop  = (state_reg == BK_IDLE) && tok_avail && (is_hdr || out_free);

    assign hdr_off  = tok.word[15:0];
    assign hdr_idx  = hdr_off[15:2] - 14'd1;
    assign hdr_bad  = (hdr_off < 16'd4)
                   || (cfg.remap_mode && ({8'd0, hdr_idx} >= total_reg));

    // restoring divide, one quotient bit per cycle
    assign trial    = {rem_reg, quo_reg[13]};
    assign trial_ge = (trial >= {1'b0, cfg.src_width_words});
    assign diff     = trial - {1'b0, cfg.src_width_words};

    assign row_prod = {11'd0, quo_reg} * {14'd0, cfg.dst_row_words};
    assign last_rel = {2'd0, rel_reg} + {1'b0, prod_reg};

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (tok_avail && is_hdr) begin
                    if (hdr_bad) begin
                        state_next = BK_IDLE;
                    end else if (cfg.remap_mode) begin
                        state_next = BK_DIV;
                    end else begin
                        state_next = BK_MUL;
                    end
                end
            end
            BK_DIV: begin
                if (div_cnt_reg == DIV_LAST) begin
                    state_next = BK_MUL;
                end
            end
            BK_MUL: state_next = BK_CHK;
            BK_CHK: state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        cnt1_next    = cnt1_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        div_cnt_next = div_cnt_reg;
        rel_next     = rel_reg;
        prod_next    = prod_reg;
        cur_next     = cur_reg;
        bad_next     = bad_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_kind_next  = m_kind_reg;
        m_addr_next  = m_addr_reg;
        m_data_next  = m_data_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (tok_pop) begin
                    unique case (tok.kind)
                        TOK_HDR: begin
                            cnt1_next    = tok.word[31:16];
                            quo_next     = hdr_idx;
                            rem_next     = '0;
                            div_cnt_next = '0;
                            cur_next     = '0;
                            bad_next     = hdr_bad;
                        end
                        TOK_END: begin
                            m_valid_next = 1'b1;
                            m_kind_next  = KIND_END;
                            m_addr_next  = '0;
                            m_data_next  = '0;
                        end
                        default: begin
                            m_valid_next = 1'b1;
                            m_data_next  = tok.word;
                            if (bad_reg) begin
                                m_kind_next = KIND_DROP;
                                m_addr_next = '0;
                            end else begin
                                m_kind_next = KIND_WRITE;
                                m_addr_next = cfg.frame_base_word + cur_reg;
                            end
                            cur_next = cur_reg + {19'd0, cfg.dst_row_words};
                        end
                    endcase
                end
            end
            BK_DIV: begin
                quo_next     = {quo_reg[12:0], trial_ge};
                rem_next     = trial_ge ? diff[10:0] : trial[10:0];
                div_cnt_next = div_cnt_reg + 4'd1;
            end
            BK_MUL: begin
                // quotient is the source row in remap mode, the index otherwise
                rel_next  = cfg.remap_mode ? ({1'b0, row_prod} + {15'd0, rem_reg})
                                           : {12'd0, quo_reg};
                prod_next = {11'd0, cnt1_reg} * {16'd0, cfg.dst_row_words};
            end
            BK_CHK: begin
                bad_next = ({4'd0, last_rel} >= FB_WORDS);
                cur_next = {4'd0, rel_reg};
            end
            default: begin
                bad_next = bad_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            div_cnt_reg <= '0;
            cur_reg     <= '0;
            bad_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
            cur_reg     <= cur_next;
            bad_reg     <= bad_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        total_reg  <= {11'd0, cfg.src_width_words} * {11'd0, cfg.src_height_rows};
        cnt1_reg   <= cnt1_next;
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        rel_reg    <= rel_next;
        prod_reg   <= prod_next;
        m_kind_reg <= m_kind_next;
        m_addr_reg <= m_addr_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_kind  = m_kind_reg;
    assign m_addr  = m_addr_reg;
    assign m_data  = m_data_reg;

    a_no_pop_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != BK_IDLE |-> !tok_pop)
        else $error("queue popped during header work");

    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == BK_DIV && div_cnt_reg == DIV_LAST) |=> state_reg == BK_MUL)
        else $error("divide did not finish after its steps");

    a_drop_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_kind_reg == KIND_DROP) |-> m_addr_reg == '0)
        else $error("dropped write carries an address");

    a_end_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_kind_reg == KIND_END) |-> (m_addr_reg == '0 && m_data_reg == '0))
        else $error("frame end carries payload");

endmodule

[sv/vertical_strip_frame_unpacker_top.sv]
// channel   direction  ports                      content
// s_        in         s_tvalid/s_tready/s_tdata  stream word [31:0]
// m_        out        m_tvalid/m_tready          m_tuser kind, m_tdata addr+data
// cfg_      in         cfg_valid/cfg_ready        cfg_index, cfg_data
//
// data and end-marker words are taken by the back end only while its output is free
// a header is worked out through BK_MUL and BK_CHK, in remap mode first through BK_DIV
// (14-step divider); a header flagged on arrival stays in BK_IDLE
// the token queue keeps taking stream words while a header is worked out
// aresetn is synchronous; no clearing pass, the block is ready after reset
// a stall on m_ tready backs up through the queue to s_tready
module vertical_strip_frame_unpacker_top #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] word
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic [63:0] m_tdata,   // [29:0] addr, [61:30] data, [63:62] zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    import vsfu_pkg::*;

    cfg_t        cfg_reg;
    tok_t        push_tok;
    tok_t        pop_tok;
    logic        q_push;
    logic        q_pop;
    logic        q_full;
    logic        q_empty;
    logic [1:0]  out_kind;
    logic [29:0] out_addr;
    logic [31:0] out_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.remap_mode      <= 1'b0;
            cfg_reg.frame_base_word <= '0;
            cfg_reg.dst_row_words   <= 11'd16;
            cfg_reg.src_width_words <= 11'd16;
            cfg_reg.src_height_rows <= 11'd342;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_REMAP_MODE:      cfg_reg.remap_mode      <= cfg_data[0];
                CFG_FRAME_BASE_WORD: cfg_reg.frame_base_word <= cfg_data[29:0];
                CFG_DST_ROW_WORDS:   cfg_reg.dst_row_words   <= cfg_data[10:0];
                CFG_SRC_WIDTH_WORDS: cfg_reg.src_width_words <= cfg_data[10:0];
                CFG_SRC_HEIGHT_ROWS: cfg_reg.src_height_rows <= cfg_data[10:0];
                default: begin
                end
            endcase
        end
    end

    vsfu_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_tok    (push_tok)
    );

    vsfu_fifo #(
        .WIDTH ($bits(tok_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wr_data (push_tok),
        .pop     (q_pop),
        .rd_data (pop_tok),
        .full    (q_full),
        .empty   (q_empty)
    );

    vsfu_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .tok       (pop_tok),
        .tok_avail (!q_empty),
        .tok_pop   (q_pop),
        .m_valid   (m_tvalid),
        .m_ready   (m_tready),
        .m_kind    (out_kind),
        .m_addr    (out_addr),
        .m_data    (out_data)
    );

    assign m_tuser = out_kind;
    assign m_tdata = {2'b00, out_data, out_addr};

endmodule

[sim/vertical_strip_frame_unpacker_top_tb.sv]
module vertical_strip_frame_unpacker_top_tb;
    import vsfu_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 2_000_000;
    localparam int unsigned DRAIN_CYCLES = 40;
    localparam int unsigned LONG_STALL   = 300;
    localparam int unsigned PHASE_ITEMS  = 100;
    localparam int unsigned NUM_DIRECTED = 37;

    typedef struct packed {
        logic [1:0]  kind;
        logic [29:0] addr;
        logic [31:0] data;
    } fb_result_t;

    typedef enum logic {
        ROW_WORD,
        ROW_REG
    } row_op_t;

    typedef struct packed {
        row_op_t     op;
        logic [2:0]  reg_idx;
        logic [31:0] word;       // stream word, or register value
        logic        typed;
        logic        has_result;
        logic [1:0]  kind;
        logic [29:0] addr;
        logic [31:0] data;
    } plan_row_t;

    // typed rows hold a result read off by hand; the others go through the predictor
    localparam plan_row_t DIRECTED [NUM_DIRECTED] = '{
        '{ROW_WORD, 3'd0, 32'h0000_0000, 1'b1, 1'b1, KIND_END,   30'd0,     32'h0000_0000},
        '{ROW_WORD, 3'd0, 32'h0000_0004, 1'b1, 1'b0, KIND_WRITE, 30'd0,     32'h0000_0000},
        '{ROW_WORD, 3'd0, 32'hFFFF_FFFF, 1'b1, 1'b1, KIND_WRITE, 30'd0,     32'hFFFF_FFFF},
        // offset below 4
        '{ROW_WORD, 3'd0, 32'h0001_0003, 1'b1, 1'b0, KIND_WRITE, 30'd0,     32'h0000_0000},
        '{ROW_WORD, 3'd0, 32'h1234_5678, 1'b1, 1'b1, KIND_DROP,  30'd0,     32'h1234_5678},
        '{ROW_WORD, 3'd0, 32'h0000_0000, 1'b1, 1'b1, KIND_DROP,  30'd0,     32'h0000_0000},
        // offset not a multiple of 4, zero word as pixel data
        '{ROW_WORD, 3'd0, 32'h0001_0007, 1'b1, 1'b0, KIND_WRITE, 30'd0,     32'h0000_0000},
        '{ROW_WORD, 3'd0, 32'hA5A5_A5A5, 1'b1, 1'b1, KIND_WRITE, 30'd0,     32'hA5A5_A5A5},
        '{ROW_WORD, 3'd0, 32'h0000_0000, 1'b1, 1'b1, KIND_WRITE, 30'd16,    32'h0000_0000},
        // largest offset, one word below the top of the framebuffer
        '{ROW_WORD, 3'd0, 32'h0000_FFFF, 1'b1, 1'b0, KIND_WRITE, 30'd0,     32'h0000_0000},
        '{ROW_WORD, 3'd0, 32'h8000_0001, 1'b1, 1'b1, KIND_WRITE, 30'd16382, 32'h8000_0001},
        // one row further runs off the framebuffer
        '{ROW_WORD, 3'd0, 32'h0001_FFFF, 1'b1, 1'b0, KIND_WRITE, 30'd0,     32'h0000_0000},
        '{ROW_WORD, 3'd0, 32'h7FFF_FFFE, 1'b1, 1'b1, KIND_DROP,  30'd0,     32'h7FFF_FFFE},
        '{ROW_WORD, 3'd0, 32'h0000_0001, 1'b1, 1'b1, KIND_DROP,  30'd0,     32'h0000_0001},
        '{ROW_WORD, 3'd0, 32'h0000_0000, 1'b1, 1'b1, KIND_END,   30'd0,     32'h0000_0000},
        // remap 5x3 source onto 1024-word rows, base near the top of the address space
        '{ROW_REG,  CFG_REMAP_MODE,      32'h0000_0001, 1'b0, 1'b0, KIND_WRITE, 30'd0, 32'd0},
        '{ROW_REG,  CFG_SRC_WIDTH_WORDS, 32'd5,         1'b0, 1'b0, KIND_WRITE, 30'd0, 32'd0},
        '{ROW_REG,  CFG_SRC_HEIGHT_ROWS, 32'd3,         1'b0, 1'b0, KIND_WRITE, 30'd0, 32'd0},
        '{ROW_REG,  CFG_DST_ROW_WORDS,   32'd1024,      1'b0, 1'b0, KIND_WRITE, 30'd0, 32'd0},
        '{ROW_REG,  CFG_FRAME_BASE_WORD, 32'h3FFF_FFF0, 1'b0, 1'b0, KIND_WRITE, 30'd0, 32'd0},
        '{ROW_WORD, 3'd0, 32'h0000_0008, 1'b0, 1'b0, KIND_WRITE, 30'd0, 32'd0},
        '{ROW_WORD, 3'd0, 32'h0F0F_0F0F, 1'b0, 1'b0, KIND_WRITE, 30'd0, 32'd0},
        // index equal to width * height
        '{ROW_WORD, 3'd0, 32'h0000_0040, 1'b0, 1'b0, KIND_WRITE, 30'd0, 32'd0},
        '{ROW_WORD, 3'd0, 32'h1357_9BDF, 1'b0, 1'b0, KIND_WRITE, 30'd0, 32'd0},
        // second source row; address wraps past the top
        '{ROW_WORD, 3'd0, 32'h0001_001C, 1'b0, 1'b0, KIND_WRITE, 30'd0, 32'd0},
        '{ROW_WORD, 3'd0, 32'hC3C3_C3C3, 1'b0, 1'b0, KIND_WRITE, 30'd0, 32'd0},
        '{ROW_WORD, 3'd0, 32'h3C3C_3C3C, 1'b0, 1'b0, KIND_WRITE, 30'd0, 32'd0},
        // zero source height flags everything
        '{ROW_REG,  CFG_SRC_HEIGHT_ROWS, 32'd0,         1'b0, 1'b0, KIND_WRITE, 30'd0, 32'd0},
        '{ROW_WORD, 3'd0, 32'h0000_0004, 1'b0, 1'b0, KIND_WRITE, 30'd0, 32'd0},
        '{ROW_WORD, 3'd0, 32'hFFFF_0000, 1'b0, 1'b0, KIND_WRITE, 30'd0, 32'd0},
        // zero stride: same address for the whole run
        '{ROW_REG,  CFG_REMAP_MODE,      32'h0000_0000, 1'b0, 1'b0, KIND_WRITE, 30'd0, 32'd0},
        '{ROW_REG,  CFG_DST_ROW_WORDS,   32'd0,         1'b0, 1'b0, KIND_WRITE, 30'd0, 32'd0},
        '{ROW_WORD, 3'd0, 32'h0002_0010, 1'b0, 1'b0, KIND_WRITE, 30'd0, 32'd0},
        '{ROW_WORD, 3'd0, 32'h1111_1111, 1'b0, 1'b0, KIND_WRITE, 30'd0, 32'd0},
        '{ROW_WORD, 3'd0, 32'h2222_2222, 1'b0, 1'b0, KIND_WRITE, 30'd0, 32'd0},
        '{ROW_WORD, 3'd0, 32'h4444_4444, 1'b0, 1'b0, KIND_WRITE, 30'd0, 32'd0},
        '{ROW_WORD, 3'd0, 32'h0000_0000, 1'b1, 1'b1, KIND_END,   30'd0,     32'h0000_0000}
    };

    logic        aclk;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [1:0]  m_tuser;    // [1:0] kind
    logic [63:0] m_tdata;    // [29:0] addr, [61:30] data, [63:62] zero
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    vertical_strip_frame_unpacker_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tuser   (m_tuser),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor copy of the registers
    logic              cfg_remap = 1'b0;
    logic [ADDR_W-1:0] cfg_base  = '0;
    logic [DIM_W-1:0]  cfg_dst   = 11'd16;
    logic [DIM_W-1:0]  cfg_srcw  = 11'd16;
    logic [DIM_W-1:0]  cfg_srch  = 11'd342;

    // predictor copy of the run state
    bit          run_active  = 1'b0;
    logic [16:0] run_left    = '0;
    logic [31:0] run_rel     = '0;
    bit          run_dropped = 1'b0;

    fb_result_t  writes_due [$];
    fb_result_t  rx_want;

    int unsigned src_idle_pct = 6;
    int unsigned dst_idle_pct = 60;
    int unsigned stalls_asked = 0;
    int unsigned stalls_done  = 0;
    logic        rx_hold      = 1'b0;

    int unsigned n_cycles  = 0;
    int unsigned n_words   = 0;
    int unsigned n_writes  = 0;
    int unsigned n_ends    = 0;
    int unsigned n_drops   = 0;
    int unsigned n_regs    = 0;
    int unsigned n_errors  = 0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles == CYCLE_LIMIT) begin
            $display("vertical_strip_frame_unpacker_top_tb: done, errors");
            $finish;
        end
    end

    // returns 1 when the word produces a result
    function automatic bit unpack_word(input logic [31:0] w, output fb_result_t res);
        logic [31:0]     count;
        logic [31:0]     off;
        logic [31:0]     idx;
        logic [31:0]     rel;
        longint unsigned cells;
        longint unsigned last;
        bit              bad;
        res.kind = KIND_END;
        res.addr = '0;
        res.data = '0;
        if (!run_active) begin
            if (w == 32'd0)
                return 1'b1;
            count = 32'(w[31:16]) + 32'd1;
            off   = 32'(w[15:0]);
            rel   = '0;
            bad   = 1'b0;
            if (off < 32'd4) begin
                bad = 1'b1;
            end else begin
                idx = off / 32'd4 - 32'd1;
                if (cfg_remap) begin
                    cells = 64'(cfg_srcw) * 64'(cfg_srch);
                    if (64'(idx) >= cells)
                        bad = 1'b1;
                    else
                        rel = (idx / 32'(cfg_srcw)) * 32'(cfg_dst) + idx % 32'(cfg_srcw);
                end else begin
                    rel = idx;
                end
            end
            if (!bad) begin
                last = 64'(rel) + 64'(count - 32'd1) * 64'(cfg_dst);
                if (last >= 64'(FB_WORDS))
                    bad = 1'b1;
            end
            run_active  = 1'b1;
            run_left    = 17'(count);
            run_rel     = rel;
            run_dropped = bad;
            return 1'b0;
        end
        res.kind = run_dropped ? KIND_DROP : KIND_WRITE;
        res.addr = run_dropped ? 30'd0 : 30'(32'(cfg_base) + run_rel);
        res.data = w;
        run_rel = run_rel + 32'(cfg_dst);
        if (run_left != 17'd0)
            run_left = run_left - 17'd1;
        if (run_left == 17'd0) begin
            run_active  = 1'b0;
            run_dropped = 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [31:0] make_header();
        logic [15:0] len_m1;
        logic [15:0] off;
        int unsigned span;
        int unsigned idx;
        case ($urandom_range(0, 19))
            0:       len_m1 = 16'($urandom_range(0, 255));
            1, 2, 3: len_m1 = 16'($urandom_range(0, 63));
            default: len_m1 = 16'($urandom_range(0, 7));
        endcase
        if ($urandom_range(0, 9) == 0) begin
            off = 16'($urandom);
        end else begin
            span = cfg_remap ? int'(cfg_srcw) * int'(cfg_srch) : 16383;
            if (span > 16383)
                span = 16383;
            if (span == 0)
                span = 1;
            idx = $urandom_range(0, span - 1);
            if ($urandom_range(0, 1) == 0)
                idx = idx % 64;
            off = 16'((idx + 1) * 4 + $urandom_range(0, 3));
        end
        // an all-zero header would read as a frame end
        if ({len_m1, off} == 32'd0)
            off = 16'd1;
        return {len_m1, off};
    endfunction

    task automatic offer_word(input logic [31:0] w);
        while ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do @(posedge aclk); while (!s_tready);
        n_words++;
    endtask

    task automatic send_word(input logic [31:0] w);
        fb_result_t res;
        if (unpack_word(w, res))
            writes_due.push_back(res);
        offer_word(w);
    endtask

    // also covers a header still being worked on after the last result
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (writes_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        case (idx)
            CFG_REMAP_MODE:      cfg_remap = value[0];
            CFG_FRAME_BASE_WORD: cfg_base  = value[ADDR_W-1:0];
            CFG_DST_ROW_WORDS:   cfg_dst   = value[DIM_W-1:0];
            CFG_SRC_WIDTH_WORDS: cfg_srcw  = value[DIM_W-1:0];
            CFG_SRC_HEIGHT_ROWS: cfg_srch  = value[DIM_W-1:0];
            default: ;
        endcase
        n_regs++;
    endtask

    // long receiver hold-off, requested by the stimulus
    initial begin
        forever begin
            @(posedge aclk);
            if (stalls_done != stalls_asked) begin
                stalls_done++;
                rx_hold <= 1'b1;
                repeat (LONG_STALL) @(posedge aclk);
                rx_hold <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (writes_due.size() == 0) begin
                $error("result with nothing expected: kind %0d addr 0x%08h data 0x%08h",
                       m_tuser, m_tdata[29:0], m_tdata[61:30]);
                n_errors++;
            end else begin
                rx_want = writes_due.pop_front();
                if (m_tuser !== rx_want.kind) begin
                    $error("kind: expected %0d, got %0d", rx_want.kind, m_tuser);
                    n_errors++;
                end
                if (m_tdata[29:0] !== rx_want.addr) begin
                    $error("addr: expected 0x%08h, got 0x%08h", rx_want.addr, m_tdata[29:0]);
                    n_errors++;
                end
                if (m_tdata[61:30] !== rx_want.data) begin
                    $error("data: expected 0x%08h, got 0x%08h", rx_want.data, m_tdata[61:30]);
                    n_errors++;
                end
            end
            case (m_tuser)
                KIND_WRITE: n_writes++;
                KIND_END:   n_ends++;
                default:    n_drops++;
            endcase
        end
        m_tready <= !rx_hold && ($urandom_range(0, 99) >= dst_idle_pct);
    end

    initial begin
        fb_result_t  typed_res;
        fb_result_t  scratch;
        logic [31:0] hdr;
        logic [31:0] base_v;
        logic [31:0] dst_v;
        logic [31:0] srcw_v;
        logic [31:0] srch_v;
        logic        remap_v;
        int unsigned ph;
        int unsigned target;
        int unsigned mid;
        int unsigned runs;
        bit          pressed;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < NUM_DIRECTED; i++) begin
            if (DIRECTED[i].op == ROW_REG) begin
                wait_drained();
                write_reg(DIRECTED[i].reg_idx, DIRECTED[i].word);
            end else if (DIRECTED[i].typed) begin
                void'(unpack_word(DIRECTED[i].word, scratch));
                if (DIRECTED[i].has_result) begin
                    typed_res.kind = DIRECTED[i].kind;
                    typed_res.addr = DIRECTED[i].addr;
                    typed_res.data = DIRECTED[i].data;
                    writes_due.push_back(typed_res);
                end
                offer_word(DIRECTED[i].word);
            end else begin
                send_word(DIRECTED[i].word);
            end
        end

        ph = 0;
        for (int mode = 0; mode < 3; mode++) begin
            src_idle_pct = (mode == 0) ? 6 : (mode == 1) ? 60 : 0;
            dst_idle_pct = (mode == 0) ? 60 : (mode == 1) ? 6 : 0;
            for (int k = 0; k < 3; k++) begin
                wait_drained();
                if (ph == 0) begin
                    remap_v = 1'b0;
                    base_v  = 32'd0;
                    dst_v   = 32'd1;
                    srcw_v  = 32'd1;
                    srch_v  = 32'd1;
                end else if (ph == 1) begin
                    remap_v = 1'b1;
                    base_v  = 32'h3FFF_FFFF;
                    dst_v   = 32'd1024;
                    srcw_v  = 32'd1024;
                    srch_v  = 32'd1024;
                end else begin
                    remap_v = 1'($urandom_range(0, 1));
                    case ($urandom_range(0, 3))
                        0:       base_v = 32'd0;
                        1:       base_v = 32'h3FFF_FFFF;
                        default: base_v = $urandom;
                    endcase
                    case ($urandom_range(0, 7))
                        0:       dst_v = 32'd0;
                        1:       dst_v = 32'd1;
                        2:       dst_v = 32'd1024;
                        3, 4:    dst_v = $urandom_range(1, 1024);
                        default: dst_v = $urandom_range(1, 32);
                    endcase
                    case ($urandom_range(0, 3))
                        0:       srcw_v = 32'd1;
                        1:       srcw_v = 32'd1024;
                        default: srcw_v = $urandom_range(1, 64);
                    endcase
                    case ($urandom_range(0, 3))
                        0:       srch_v = 32'd1;
                        1:       srch_v = 32'd1024;
                        default: srch_v = $urandom_range(1, 400);
                    endcase
                end
                write_reg(CFG_REMAP_MODE, {31'd0, remap_v});
                write_reg(CFG_FRAME_BASE_WORD, base_v);
                write_reg(CFG_DST_ROW_WORDS, dst_v);
                write_reg(CFG_SRC_WIDTH_WORDS, srcw_v);
                write_reg(CFG_SRC_HEIGHT_ROWS, srch_v);
                ph++;

                target  = n_words + PHASE_ITEMS;
                mid     = n_words + PHASE_ITEMS / 2;
                pressed = 1'b0;
                while (n_words < target) begin
                    if (!pressed && n_words >= mid) begin
                        pressed = 1'b1;
                        if (mode == 0)
                            stalls_asked++;
                        else if (mode == 1)
                            wait_drained();
                    end
                    if ($urandom_range(0, 9) == 0) begin
                        // stray end markers and short headers out of frame order
                        if ($urandom_range(0, 1) == 0) begin
                            send_word(32'd0);
                        end else begin
                            send_word({14'd0, 2'($urandom_range(0, 3)), 16'($urandom)} | 32'd1);
                            // fill the short run so later headers stay headers
                            while (run_active)
                                send_word($urandom);
                        end
                    end else begin
                        runs = $urandom_range(1, 4);
                        for (int r = 0; r < runs; r++) begin
                            hdr = make_header();
                            send_word(hdr);
                            for (int j = 0; j <= int'(hdr[31:16]); j++)
                                send_word(($urandom_range(0, 15) == 0) ? 32'd0 : $urandom);
                        end
                        send_word(32'd0);
                    end
                end
                // finish any open run before the registers change
                while (run_active)
                    send_word($urandom);
            end
        end

        // long run at zero stride stays in range
        wait_drained();
        write_reg(CFG_REMAP_MODE, 32'd0);
        write_reg(CFG_DST_ROW_WORDS, 32'd0);
        send_word(32'h001F_0004);
        repeat (32) send_word($urandom);
        send_word(32'd0);
        wait_drained();

        $display("covered %0d stream words over %0d register writes", n_words, n_regs);
        $display("results seen: %0d writes, %0d frame ends, %0d dropped writes",
                 n_writes, n_ends, n_drops);
        if (n_errors == 0) begin
            $display("vertical_strip_frame_unpacker_top_tb: done, clean");
        end else begin
            $display("vertical_strip_frame_unpacker_top_tb: done, errors");
        end
        $finish;
    end

endmodule
